// ----- hw/rtl/mtrc_pkg.sv -----
package mtrc_pkg;

	// Field widths
	localparam int ADDR_W       = 48;
	localparam int DELAY_W      = 32;
	localparam int SIZE_W       = 31;
	localparam int IDX_IN_W     = 6;
	localparam int CNT_W        = 48;
	localparam int TOKEN_W      = 16;
	localparam int PAGE_W       = 7;
	localparam int CAT_W        = 3;
	localparam int PHASE_W      = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 48;
	localparam int SEGMENTS_DEF = 64;

	// Item kinds
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_TRACE = 1'b1;

	// Result categories
	localparam logic [CAT_W-1:0] CAT_NONE    = 3'd0;
	localparam logic [CAT_W-1:0] CAT_DRAM_LD = 3'd1;
	localparam logic [CAT_W-1:0] CAT_DRAM_ST = 3'd2;
	localparam logic [CAT_W-1:0] CAT_SCM_LD  = 3'd3;
	localparam logic [CAT_W-1:0] CAT_SCM_ST  = 3'd4;
	localparam logic [CAT_W-1:0] CAT_LOG_LD  = 3'd5;
	localparam logic [CAT_W-1:0] CAT_LOG_ST  = 3'd6;

	// Run phases
	localparam logic [PHASE_W-1:0] PH_WAIT = 2'd0;
	localparam logic [PHASE_W-1:0] PH_RUN  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_END  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_END   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_TOKENS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_PAGES     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd4;

	// Tally bank slots; category c lands in slot T_CAT0 + c - 1
	localparam int TALLY_N     = 9;
	localparam int TALLY_IDX_W = 4;
	localparam int T_SEEN      = 0;
	localparam int T_RUN       = 1;
	localparam int T_CAT0      = 2;
	localparam int T_CYC       = 8;

	typedef struct packed {
		logic [ADDR_W-1:0]  program_start;
		logic [ADDR_W-1:0]  program_end;
		logic [TOKEN_W-1:0] start_tokens;
		logic [PAGE_W-1:0]  log_pages;
		logic [PAGE_W-1:0]  segment_count;
	} mtrc_cfg_t;

	// Decoded word handed from front to back
	typedef struct packed {
		logic                op;
		logic                is_write;
		logic                start_hit;
		logic                end_hit;
		logic [ADDR_W-1:0]   address;
		logic [DELAY_W-1:0]  delay_cycles;
		logic [IDX_IN_W-1:0] entry_index;
		logic [ADDR_W-1:0]   entry_start;
		logic [SIZE_W-1:0]   entry_size;
	} mtrc_cmd_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
			input logic [DELAY_W-1:0] d);
		logic [CNT_W:0] s;
		s = {1'b0, v} + (CNT_W+1)'(d);
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/mtrc_front.sv -----
module mtrc_front import mtrc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic                is_write,
	input  logic [ADDR_W-1:0]   address,
	input  logic [DELAY_W-1:0]  delay_cycles,
	input  logic [IDX_IN_W-1:0] entry_index,
	input  logic [ADDR_W-1:0]   entry_start,
	input  logic [SIZE_W-1:0]   entry_size,
	input  mtrc_cfg_t           cfg,
	output logic                cmd_valid,
	output mtrc_cmd_t           cmd,
	input  logic                cmd_pop
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = 1;
	localparam int CNT_QW = 2;

	mtrc_cmd_t          queue_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               push;
	mtrc_cmd_t          word_d;

	// Decode the incoming word and mark start and end addresses
	always_comb begin
		word_d.op           = op;
		word_d.is_write     = is_write;
		word_d.start_hit    = (address == cfg.program_start);
		word_d.end_hit      = (address == cfg.program_end);
		word_d.address      = address;
		word_d.delay_cycles = delay_cycles;
		word_d.entry_index  = entry_index;
		word_d.entry_start  = entry_start;
		word_d.entry_size   = entry_size;
	end

	assign in_stall  = (count_q == CNT_QW'(QDEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// Store decoded words
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= word_d;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mtrc_back.sv -----
module mtrc_back import mtrc_pkg::*; #(
	parameter int SEGMENTS = SEGMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mtrc_cfg_t          cfg,
	input  logic               cmd_valid,
	input  mtrc_cmd_t          cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CAT_W-1:0]   category,
	output logic [PHASE_W-1:0] phase,
	output logic [CNT_W-1:0]   records_seen,
	output logic [CNT_W-1:0]   records_counted,
	output logic [CNT_W-1:0]   dram_loads,
	output logic [CNT_W-1:0]   dram_stores,
	output logic [CNT_W-1:0]   scm_loads,
	output logic [CNT_W-1:0]   scm_stores,
	output logic [CNT_W-1:0]   log_loads,
	output logic [CNT_W-1:0]   log_stores,
	output logic [CNT_W-1:0]   cycle_total
);

	localparam int IDX_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int LIM_R  = $clog2(SEGMENTS + 1);
	localparam int LIM_W  = (LIM_R > PAGE_W) ? LIM_R : PAGE_W;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	// Segment table
	logic [ADDR_W-1:0]   seg_start_mem [SEGMENTS];
	logic [SIZE_W-1:0]   seg_size_mem  [SEGMENTS];
	logic [ADDR_W-1:0]   rd_start_q;
	logic [SIZE_W-1:0]   rd_size_q;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [LIM_W-1:0]    idx_ext;
	logic                mem_we;

	// Sequencer state
	state_t              state_q;
	logic [IDX_W-1:0]    cur_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                wr_q;
	logic [DELAY_W-1:0]  delay_q;
	logic                out_valid_q;
	logic [CAT_W-1:0]    cat_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [TOKEN_W-1:0]  hits_q;
	logic [CNT_W-1:0]    tally_q [TALLY_N];

	logic [LIM_W-1:0]    seg_lim;
	logic                out_free;
	logic                is_trace;
	logic                need_search;
	logic                seg_hit;
	logic                last;
	logic                search_done;
	logic                search_fin;
	logic                idle_fin;
	logic                seen_inc;
	logic                counted;
	logic [CAT_W-1:0]    search_cat;
	logic [CAT_W-1:0]    miss_cat;
	logic [CAT_W-1:0]    cat_d;
	logic [DELAY_W-1:0]  delay_d;
	logic [TALLY_IDX_W-1:0] cat_idx;
	logic [TOKEN_W-1:0]  hits_next;

	// Clamp the searched entry count to the table depth
	assign seg_lim = (LIM_W'(cfg.segment_count) > LIM_W'(SEGMENTS)) ?
		LIM_W'(SEGMENTS) : LIM_W'(cfg.segment_count);

	assign out_free    = !out_valid_q || !out_stall;
	assign is_trace    = (cmd.op == OP_TRACE);
	assign need_search = is_trace && (phase_q == PH_RUN) && !cmd.end_hit &&
		(seg_lim != '0);
	assign cmd_pop     = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign hits_next   = (&hits_q) ? hits_q : hits_q + 1'b1;

	// Compare the entry whose data sits in the read register
	assign seg_hit = (addr_q >= rd_start_q) &&
		((addr_q - rd_start_q) <= ADDR_W'(rd_size_q));
	assign last        = ((LIM_W'(cur_q) + LIM_W'(1)) == seg_lim);
	assign search_done = (state_q == ST_SEARCH) && (seg_hit || last);
	assign search_fin  = search_done && out_free;
	assign idle_fin    = cmd_pop && !need_search;

	// Pick the category of a finished search
	always_comb begin
		if (!seg_hit) begin
			search_cat = wr_q ? CAT_DRAM_ST : CAT_DRAM_LD;
		end else if (LIM_W'(cur_q) < LIM_W'(cfg.log_pages)) begin
			search_cat = wr_q ? CAT_LOG_ST : CAT_LOG_LD;
		end else begin
			search_cat = wr_q ? CAT_SCM_ST : CAT_SCM_LD;
		end
	end

	// Work out which tallies move this cycle; a record is seen once, when popped
	assign miss_cat = cmd.is_write ? CAT_DRAM_ST : CAT_DRAM_LD;
	assign seen_inc = cmd_pop && is_trace && (phase_q != PH_END);
	assign counted  = (idle_fin && is_trace && (phase_q == PH_RUN) && !cmd.end_hit) ||
		search_fin;
	assign cat_d    = search_fin ? search_cat : (counted ? miss_cat : CAT_NONE);
	assign delay_d  = search_fin ? delay_q : cmd.delay_cycles;
	assign cat_idx  = TALLY_IDX_W'(T_CAT0 - 1) + TALLY_IDX_W'(cat_d);

	// Select the next table read
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = '0;
		end else if (search_done) begin
			rd_addr = cur_q;
		end else begin
			rd_addr = cur_q + 1'b1;
		end
	end

	// Write segment entries from load words
	assign idx_ext = LIM_W'(cmd.entry_index);
	assign wr_addr = idx_ext[IDX_W-1:0];
	assign mem_we  = cmd_pop && (cmd.op == OP_LOAD) && (idx_ext < LIM_W'(SEGMENTS));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seg_start_mem[wr_addr] <= cmd.entry_start;
			seg_size_mem[wr_addr]  <= cmd.entry_size;
		end
		rd_start_q <= seg_start_mem[rd_addr];
		rd_size_q  <= seg_size_mem[rd_addr];
	end

	// Sequence words, track phase and update the tally bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			addr_q      <= '0;
			wr_q        <= 1'b0;
			delay_q     <= '0;
			out_valid_q <= 1'b0;
			cat_q       <= CAT_NONE;
			phase_q     <= PH_WAIT;
			hits_q      <= '0;
			for (int i = 0; i < TALLY_N; i++) begin
				tally_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						addr_q  <= cmd.address;
						wr_q    <= cmd.is_write;
						delay_q <= cmd.delay_cycles;
						cur_q   <= '0;
						if (need_search) begin
							state_q <= ST_SEARCH;
						end else begin
							out_valid_q <= 1'b1;
							cat_q       <= cat_d;
							if (is_trace && (phase_q == PH_WAIT) && cmd.start_hit) begin
								hits_q <= hits_next;
								if (hits_next >= cfg.start_tokens) begin
									phase_q <= PH_RUN;
								end
							end
							if (is_trace && (phase_q == PH_RUN) && cmd.end_hit) begin
								phase_q <= PH_END;
							end
						end
					end
				end
				ST_SEARCH: begin
					if (search_fin) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						cat_q       <= cat_d;
					end else if (!search_done) begin
						cur_q <= cur_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (seen_inc) begin
				tally_q[T_SEEN] <= sat_inc(tally_q[T_SEEN]);
			end
			if (counted) begin
				tally_q[T_RUN] <= sat_inc(tally_q[T_RUN]);
				tally_q[T_CYC] <= sat_add(tally_q[T_CYC], delay_d);
				for (int i = T_CAT0; i < T_CYC; i++) begin
					if (cat_idx == TALLY_IDX_W'(i)) begin
						tally_q[i] <= sat_inc(tally_q[i]);
					end
				end
			end
		end
	end

	// Counters hold still while a result waits, so drive them directly
	assign out_valid       = out_valid_q;
	assign category        = cat_q;
	assign phase           = phase_q;
	assign records_seen    = tally_q[T_SEEN];
	assign records_counted = tally_q[T_RUN];
	assign dram_loads      = tally_q[T_CAT0];
	assign dram_stores     = tally_q[T_CAT0 + 1];
	assign scm_loads       = tally_q[T_CAT0 + 2];
	assign scm_stores      = tally_q[T_CAT0 + 3];
	assign log_loads       = tally_q[T_CAT0 + 4];
	assign log_stores      = tally_q[T_CAT0 + 5];
	assign cycle_total     = tally_q[T_CYC];

	a_search_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (phase_q == PH_RUN))
		else $error("segment search outside the counting phase");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (LIM_W'(cur_q) < seg_lim))
		else $error("search pointer beyond searched entries");

	a_counted_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q[T_RUN] <= tally_q[T_SEEN])
		else $error("counted records exceed seen records");

	a_search_result: assert property (@(posedge clk) disable iff (!arst_n)
		search_fin |=> (out_valid_q && (cat_q != CAT_NONE)))
		else $error("finished search gave no counted result");

	a_end_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_END) |=> (phase_q == PH_END))
		else $error("ended phase left");

endmodule

// ----- hw/rtl/memory_trace_region_classifier.sv -----
// Memory-trace region classifier.
// Input channel (in_valid / in_stall): one word per load or trace record. A load
// word fills its slot if the index fits; a trace word is classified and counted.
// Output channel (out_valid / out_stall): exactly one result word per input word,
// in order, with the category and all counters as they stand after that word.
// Config channel (cfg_valid / cfg_ready, always ready): write registers only
// while the block is idle.
// Load words and records that need no table search go from the queue straight
// to the result register. A record that needs a search compares table entries
// from entry 0 up until one hits or the clamped segment count is reached, one
// entry per cycle through the single registered read port of the segment table;
// the back end takes no new word until the search ends, and a two-word queue
// lets the input keep accepting while the back end searches.
// When the receiver stalls, the result word and counters hold and the back end
// stops taking words; the queue fills and then stalls the input.
// Reset clears phase, start hit count, counters and configuration (start_tokens
// to 1); the segment table is not cleared and must be loaded before it is searched.
module memory_trace_region_classifier import mtrc_pkg::*; #(
	parameter int SEGMENTS = SEGMENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic                  is_write,
	input  logic [ADDR_W-1:0]     address,
	input  logic [DELAY_W-1:0]    delay_cycles,
	input  logic [IDX_IN_W-1:0]   entry_index,
	input  logic [ADDR_W-1:0]     entry_start,
	input  logic [SIZE_W-1:0]     entry_size,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CAT_W-1:0]      category,
	output logic [PHASE_W-1:0]    phase,
	output logic [CNT_W-1:0]      records_seen,
	output logic [CNT_W-1:0]      records_counted,
	output logic [CNT_W-1:0]      dram_loads,
	output logic [CNT_W-1:0]      dram_stores,
	output logic [CNT_W-1:0]      scm_loads,
	output logic [CNT_W-1:0]      scm_stores,
	output logic [CNT_W-1:0]      log_loads,
	output logic [CNT_W-1:0]      log_stores,
	output logic [CNT_W-1:0]      cycle_total,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mtrc_cfg_t cfg_q;
	logic      cmd_valid;
	logic      cmd_pop;
	mtrc_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.program_start <= '0;
			cfg_q.program_end   <= '0;
			cfg_q.start_tokens  <= TOKEN_W'(1);
			cfg_q.log_pages     <= '0;
			cfg_q.segment_count <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROGRAM_START: cfg_q.program_start <= cfg_data[ADDR_W-1:0];
				REG_PROGRAM_END:   cfg_q.program_end   <= cfg_data[ADDR_W-1:0];
				REG_START_TOKENS:  cfg_q.start_tokens  <= cfg_data[TOKEN_W-1:0];
				REG_LOG_PAGES:     cfg_q.log_pages     <= cfg_data[PAGE_W-1:0];
				REG_SEGMENT_COUNT: cfg_q.segment_count <= cfg_data[PAGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mtrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.is_write     (is_write),
		.address      (address),
		.delay_cycles (delay_cycles),
		.entry_index  (entry_index),
		.entry_start  (entry_start),
		.entry_size   (entry_size),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	mtrc_back #(
		.SEGMENTS (SEGMENTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.category        (category),
		.phase           (phase),
		.records_seen    (records_seen),
		.records_counted (records_counted),
		.dram_loads      (dram_loads),
		.dram_stores     (dram_stores),
		.scm_loads       (scm_loads),
		.scm_stores      (scm_stores),
		.log_loads       (log_loads),
		.log_stores      (log_stores),
		.cycle_total     (cycle_total)
	);

endmodule
